[hw/rtl/shared_pool_message_queues_defines.svh]
// Assertion macros shared by the queue manager modules
`ifndef SHARED_POOL_MESSAGE_QUEUES_DEFINES_SVH
`define SHARED_POOL_MESSAGE_QUEUES_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SPMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/spmq_pkg.sv]
// Shared types and codes for the message queue manager
package spmq_pkg;
  localparam int unsigned PoolSlots  = 16;
  localparam int unsigned QueueCount = 4;
  localparam int unsigned SignalBits = 32;
  localparam int unsigned SlotW      = $clog2(PoolSlots);
  localparam int unsigned CntW       = $clog2(PoolSlots + 1);
  localparam int unsigned QidW       = 2;
  localparam int unsigned CfgW       = 2;

  typedef enum logic [1:0] {
    OpPut  = 2'd0,
    OpGet  = 2'd1,
    OpFree = 2'd2,
    OpNop  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StQFull  = 3'd1,
    StPFull  = 3'd2,
    StQEmpty = 3'd3,
    StNone   = 3'd4
  } status_e;

  typedef struct packed {
    op_e                     operation;
    logic [QidW-1:0]         queue_id;
    logic signed [31:0]      signal_in;
    logic [3:0]              slot_in;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [3:0]              slot_out;
    logic signed [31:0]      signal_out;
    logic [4:0]              pool_in_use;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    op_e                     op;
    logic [QidW-1:0]         qid;
    logic [SignalBits-1:0]   sig;
    logic [SlotW-1:0]        slot;
  } cmd_t;
endpackage

[hw/rtl/spmq_front.sv]
// Front end: request intake and two-entry command queue
module spmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  spmq_pkg::req_t  req_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output spmq_pkg::cmd_t  cmd_o
);
  import spmq_pkg::*;
  `include "shared_pool_message_queues_defines.svh"

  cmd_t     buf_q [2];
  logic     wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t     cmd_in;
  logic     do_wr, do_rd;

  always_comb begin
    cmd_in.op   = req_i.operation;
    cmd_in.qid  = req_i.queue_id;
    cmd_in.sig  = SignalBits'(req_i.signal_in);
    cmd_in.slot = req_i.slot_in[SlotW-1:0];
  end

  assign full        = cnt_q == 2'd2;
  assign do_wr       = push && !full;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign do_rd       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) buf_q[wr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

  `SPMQ_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3, "command queue count overflow")
  `SPMQ_ASSERT_NEXT(a_full_hold, full && !do_rd, full, "full dropped without a read")
  `SPMQ_ASSERT_IMP(a_ptr_sync, cnt_q == 2'd1, wr_q != rd_q, "pointers out of step")
endmodule

[hw/rtl/spmq_back.sv]
// Back end: free list, queue links and result register
module spmq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  spmq_pkg::cmd_t  cmd_i,
  input  logic [4:0]      cap_i [spmq_pkg::QueueCount],
  output logic            empty,
  input  logic            pop,
  output spmq_pkg::rsp_t  rsp_o
);
  import spmq_pkg::*;
  `include "shared_pool_message_queues_defines.svh"

  logic [SlotW-1:0]      link_q [PoolSlots];
  logic [SignalBits-1:0] sig_mem [PoolSlots];
  logic [SlotW-1:0]      free_head_q;
  logic [CntW-1:0]       used_q;
  logic [SlotW-1:0]      head_q [QueueCount];
  logic [SlotW-1:0]      tail_q [QueueCount];
  logic [CntW-1:0]       qcnt_q [QueueCount];
  logic                  rvalid_q;
  rsp_t                  rsp_q;

  logic                  go, do_put, do_get, do_free;
  status_e               st;
  logic [SlotW-1:0]      gslot;
  logic [CntW-1:0]       used_d;

  assign cmd_ready_o = !rvalid_q || pop;
  assign go          = cmd_valid_i && cmd_ready_o;
  assign empty       = !rvalid_q;
  assign rsp_o       = rsp_q;
  assign gslot       = head_q[cmd_i.qid];

  always_comb begin
    st      = StOk;
    do_put  = 1'b0;
    do_get  = 1'b0;
    do_free = 1'b0;
    unique case (cmd_i.op)
      OpPut: begin
        if (qcnt_q[cmd_i.qid] >= cap_i[cmd_i.qid]) st = StQFull;
        else if (used_q >= CntW'(PoolSlots)) st = StPFull;
        else do_put = 1'b1;
      end
      OpGet: begin
        if (qcnt_q[cmd_i.qid] == '0) st = StQEmpty;
        else do_get = 1'b1;
      end
      OpFree: begin
        if (used_q == '0) st = StNone;
        else do_free = 1'b1;
      end
      default: ;
    endcase
    used_d = used_q;
    if (go && do_put)  used_d = used_q + 1'b1;
    if (go && do_free) used_d = used_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (go && do_put) sig_mem[free_head_q] <= cmd_i.sig;
    if (go) begin
      rsp_q.status      <= st;
      rsp_q.slot_out    <= do_put ? free_head_q : (do_get ? gslot : '0);
      rsp_q.signal_out  <= do_get ? sig_mem[gslot] : '0;
      rsp_q.pool_in_use <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PoolSlots; i++) link_q[i] <= SlotW'(i + 1);
      for (int i = 0; i < QueueCount; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        qcnt_q[i] <= '0;
      end
      free_head_q <= '0;
      used_q      <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (go) rvalid_q <= 1'b1;
      else if (pop) rvalid_q <= 1'b0;
      used_q <= used_d;
      if (go && do_put) begin
        free_head_q <= link_q[free_head_q];
        if (qcnt_q[cmd_i.qid] == '0) head_q[cmd_i.qid] <= free_head_q;
        else link_q[tail_q[cmd_i.qid]] <= free_head_q;
        link_q[free_head_q]  <= '0;
        tail_q[cmd_i.qid]    <= free_head_q;
        qcnt_q[cmd_i.qid]    <= qcnt_q[cmd_i.qid] + 1'b1;
      end
      if (go && do_get) begin
        if (qcnt_q[cmd_i.qid] == CntW'(1)) begin
          head_q[cmd_i.qid] <= '0;
          tail_q[cmd_i.qid] <= '0;
        end else begin
          head_q[cmd_i.qid] <= link_q[gslot];
        end
        qcnt_q[cmd_i.qid] <= qcnt_q[cmd_i.qid] - 1'b1;
      end
      if (go && do_free) begin
        link_q[cmd_i.slot] <= free_head_q;
        free_head_q        <= cmd_i.slot;
      end
    end
  end

  `SPMQ_ASSERT_IMP(a_used_max, 1'b1, used_q <= CntW'(PoolSlots), "pool count overflow")
  `SPMQ_ASSERT_NEXT(a_rsp_hold, rvalid_q && !pop, rvalid_q && $stable(rsp_q),
    "stalled result changed")
  `SPMQ_ASSERT_NEXT(a_put_count, go && do_put, used_q == $past(used_q) + 1'b1,
    "put did not allocate")
  `SPMQ_ASSERT_IMP(a_ok_status, go && (do_put || do_get || do_free), st == StOk,
    "executed request with error status")
endmodule

[hw/rtl/shared_pool_message_queues.sv]
// Top level of the shared-pool message queue manager
//
// Requests enter a queue-style port: drive req_i and raise push while full is
// low. Each request (put, get, free or nop) gives exactly one result, read
// from the output side while empty is low and taken with pop. A two-entry
// command queue decouples intake from execution; the back end runs one
// request per cycle while its result is taken. A request is stored in the
// command queue and then executed into the result register. Sustained
// throughput is one request per cycle while pop stays high.
// Capacity registers are written through cfg_valid_i/cfg_ready_i with an
// index 0..3 and 5-bit data; the port is always ready.
// Reset links all slots into the free list, empties every queue and sets all
// capacities to 16 at once; no clearing pass is needed.
// While pop stays low the result holds, the back end stops, and the command
// queue fills; full then rises and further requests wait.
module shared_pool_message_queues (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  spmq_pkg::req_t  req_i,
  output logic            empty,
  input  logic            pop,
  output spmq_pkg::rsp_t  rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [4:0]      cfg_data_i
);
  import spmq_pkg::*;

  logic [4:0] cap_q [QueueCount];
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QueueCount; i++) cap_q[i] <= 5'd16;
    end else if (cfg_valid_i) begin
      cap_q[cfg_index_i] <= cfg_data_i;
    end
  end

  spmq_front u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  spmq_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cap_i(cap_q), .empty, .pop, .rsp_o
  );
endmodule
